// ----- rtl/mcadpcm_pkg.sv -----
// ---------------------------------------------------------------------------
// mcadpcm_pkg: shared types and constants of the multichannel ADPCM decoder
// Field widths, predictor coefficient table and control bundles used by the
// core, the channel state file and the shared multiply-accumulate unit.
// ---------------------------------------------------------------------------
package mcadpcm_pkg;

   // Payload field widths
   localparam int BYTE_W   = 8;
   localparam int NIB_W    = 4;
   localparam int SAMPLE_W = 16;
   localparam int CHAN_W   = 3;
   localparam int CNT_W    = 4;

   // Per-channel state widths
   localparam int COEF_W  = 10;
   localparam int SHIFT_W = 5;
   localparam int PROD_W  = SAMPLE_W + COEF_W;
   localparam int ACC_W   = 36;

   // Decode constants
   localparam int SHIFT_BIAS = 8;
   localparam int SHIFT_BASE = 28;
   localparam int ROUND_BIAS = 'h80;
   localparam int FRAC_BITS  = 8;
   localparam int SAMPLE_MAX = 32767;
   localparam int SAMPLE_MIN = -32768;
   localparam int COEF2_OFS  = 4;
   localparam int COEF_IDX_W = 5;

   // Default configuration
   localparam int MAX_CHANNELS_DEF   = 8;
   localparam int ROWS_PER_BLOCK_DEF = 15;

   // Shared arithmetic unit control
   typedef struct packed {
      logic load;    // start a decode: product of first tap, load code term
      logic accum;   // product of second tap, fold previous product
   } mac_ctl_type;

   // Channel state file write controls
   typedef struct packed {
      logic clear;   // zero every channel's history, coefficients and shift
      logic hdr_we;  // header byte: coefficients and shift
      logic pend_we; // hold the low nibble of a data byte
      logic smp_we;  // shift history: prev <= cur, cur <= new sample
   } chan_ctl_type;

   // Predictor coefficient table, twenty entries
   function automatic logic signed [COEF_W-1:0] coef_lookup(input logic [COEF_IDX_W-1:0] idx);
      logic signed [COEF_W-1:0] c;
      unique case (idx)
         5'd0:    c = 10'sd0;
         5'd1:    c = 10'sd240;
         5'd2:    c = 10'sd460;
         5'd3:    c = 10'sd392;
         5'd4:    c = 10'sd0;
         5'd5:    c = 10'sd0;
         5'd6:    c = -10'sd208;
         5'd7:    c = -10'sd220;
         5'd8:    c = 10'sd0;
         5'd9:    c = 10'sd1;
         5'd10:   c = 10'sd3;
         5'd11:   c = 10'sd4;
         5'd12:   c = 10'sd7;
         5'd13:   c = 10'sd8;
         5'd14:   c = 10'sd10;
         5'd15:   c = 10'sd11;
         5'd16:   c = 10'sd0;
         5'd17:   c = -10'sd1;
         5'd18:   c = -10'sd3;
         5'd19:   c = -10'sd4;
         default: c = 10'sd0;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/mcadpcm_req_if.sv -----
// ---------------------------------------------------------------------------
// mcadpcm_req_if: compressed byte request channel
// Valid/ready handshake carrying one stream byte per request.
// ---------------------------------------------------------------------------
interface mcadpcm_req_if import mcadpcm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- rtl/mcadpcm_rsp_if.sv -----
// ---------------------------------------------------------------------------
// mcadpcm_rsp_if: decoded sample response channel
// Valid/ready handshake carrying one PCM sample with its channel and a
// marker on the final sample of a request.
// ---------------------------------------------------------------------------
interface mcadpcm_rsp_if import mcadpcm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic [CHAN_W-1:0]          channel;
   logic                       last;

   modport source (output valid, output sample, output channel, output last, input ready);
   modport sink   (input valid, input sample, input channel, input last, output ready);
endinterface

// ----- rtl/multichannel_adpcm_block_decoder_core.sv -----
// ---------------------------------------------------------------------------
// multichannel_adpcm_block_decoder_core: multichannel block ADPCM decoder
// Sequencer that walks header and data rows and drives one shared
// multiply-accumulate unit, one decode after another, into a response
// register.
// ---------------------------------------------------------------------------
// Header-row request: accepted and applied, no response.
// Data-row request: three steps in the shared multiplier (first tap,
// second tap, clip); the last channel of a row then runs the same three
// steps for each held low nibble of the row.
// A stalled response register holds the sequencer in its clip step.
// Reset (synchronous) sets channel count to 1 and zeroes channel history, coefficients and shift.
// ---------------------------------------------------------------------------
module multichannel_adpcm_block_decoder_core import mcadpcm_pkg::*; #(
   parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF,
   parameter int ROWS_PER_BLOCK = ROWS_PER_BLOCK_DEF
) (
   input  logic               clock,
   input  logic               reset,
   mcadpcm_req_if.sink        req_if,
   mcadpcm_rsp_if.source      rsp_if,
   input  logic               csr_we,
   input  logic [CNT_W-1:0]   csr_wdata
);

   localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int ROW_W = $clog2(ROWS_PER_BLOCK);

   // Sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL1 = 2'd1;
   localparam logic [1:0] ST_MUL2 = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CH_W-1:0]  ch_ff, ch_in;
   logic [CH_W-1:0]  last_ch_ff, last_ch_in;
   logic [CH_W-1:0]  dch_ff, dch_in;
   logic             low_ff, low_in;
   logic             wrap_ff, wrap_in;
   logic [NIB_W-1:0] code_ff, code_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic [CHAN_W-1:0]          rsp_channel_ff, rsp_channel_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic         req_fire;
   logic         out_free;
   logic         emit;
   logic         row_end;
   chan_ctl_type chan_ctl;
   mac_ctl_type  mac_ctl;

   logic signed [SAMPLE_W-1:0] rd_cur;
   logic signed [SAMPLE_W-1:0] rd_prev;
   logic signed [COEF_W-1:0]   rd_coef1;
   logic signed [COEF_W-1:0]   rd_coef2;
   logic [SHIFT_W-1:0]         rd_shift;
   logic [NIB_W-1:0]           rd_pend;
   logic signed [SAMPLE_W-1:0] mac_sample;
   logic signed [SAMPLE_W-1:0] mul_a;
   logic signed [COEF_W-1:0]   mul_b;
   logic [NIB_W-1:0]           mac_code;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign emit         = (state_ff == ST_EMIT) && out_free;
   assign row_end      = (ch_ff == last_ch_ff);

   // Channel state file
   mcadpcm_chan #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .CH_W         (CH_W)
   ) u_chan (
      .clock    (clock),
      .reset    (reset),
      .ctl      (chan_ctl),
      .wr_ch    (ch_ff),
      .wr_byte  (req_if.in_byte),
      .rd_ch    (dch_ff),
      .smp_data (mac_sample),
      .rd_cur   (rd_cur),
      .rd_prev  (rd_prev),
      .rd_coef1 (rd_coef1),
      .rd_coef2 (rd_coef2),
      .rd_shift (rd_shift),
      .rd_pend  (rd_pend)
   );

   // Feed the shared unit: first tap, then second tap
   always_comb begin
      mac_ctl.load  = (state_ff == ST_MUL1);
      mac_ctl.accum = (state_ff == ST_MUL2);
      mul_a         = (state_ff == ST_MUL2) ? rd_prev : rd_cur;
      mul_b         = (state_ff == ST_MUL2) ? rd_coef2 : rd_coef1;
      mac_code      = low_ff ? rd_pend : code_ff;
   end

   mcadpcm_mac u_mac (
      .clock  (clock),
      .ctl    (mac_ctl),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .code   (mac_code),
      .shift  (rd_shift),
      .sample (mac_sample)
   );

   // Channel state writes
   always_comb begin
      chan_ctl.clear   = csr_we;
      chan_ctl.hdr_we  = req_fire && (row_ff == '0);
      chan_ctl.pend_we = req_fire && (row_ff != '0);
      chan_ctl.smp_we  = emit;
   end

   // Sequencer, row/channel position and channel count
   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      ch_in      = ch_ff;
      last_ch_in = last_ch_ff;
      dch_in     = dch_ff;
      low_in     = low_ff;
      wrap_in    = wrap_ff;
      code_in    = code_ff;

      if (csr_we) begin
         row_in = '0;
         ch_in  = '0;
         if (csr_wdata == '0) begin
            last_ch_in = '0;
         end else if (int'(csr_wdata) > MAX_CHANNELS) begin
            last_ch_in = CH_W'(MAX_CHANNELS - 1);
         end else begin
            last_ch_in = CH_W'(csr_wdata - CNT_W'(1));
         end
      end else if (req_fire) begin
         // Advance the stream position on every request
         if (row_end) begin
            ch_in = '0;
            if (row_ff == ROW_W'(ROWS_PER_BLOCK - 1)) begin
               row_in = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            ch_in = ch_ff + CH_W'(1);
         end
         // Start the high-nibble decode on a data row
         if (row_ff != '0) begin
            code_in  = req_if.in_byte[BYTE_W-1:NIB_W];
            dch_in   = ch_ff;
            low_in   = 1'b0;
            wrap_in  = row_end;
            state_in = ST_MUL1;
         end
      end

      unique case (state_ff)
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit) begin
               if (!low_ff && !wrap_ff) begin
                  state_in = ST_IDLE;
               end else if (!low_ff) begin
                  low_in   = 1'b1;
                  dch_in   = '0;
                  state_in = ST_MUL1;
               end else if (dch_ff == last_ch_ff) begin
                  low_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  dch_in   = dch_ff + CH_W'(1);
                  state_in = ST_MUL1;
               end
            end
         end
         default: ;
      endcase
   end

   // Response register: load on emit, drop when taken
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_sample_in  = rsp_sample_ff;
      rsp_channel_in = rsp_channel_ff;
      rsp_last_in    = rsp_last_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_sample_in  = mac_sample;
         rsp_channel_in = CHAN_W'(dch_ff);
         rsp_last_in    = low_ff ? (dch_ff == last_ch_ff) : !wrap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         ch_ff        <= '0;
         last_ch_ff   <= '0;
         dch_ff       <= '0;
         low_ff       <= 1'b0;
         wrap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         ch_ff        <= ch_in;
         last_ch_ff   <= last_ch_in;
         dch_ff       <= dch_in;
         low_ff       <= low_in;
         wrap_ff      <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff        <= code_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.sample  = rsp_sample_ff;
   assign rsp_if.channel = rsp_channel_ff;
   assign rsp_if.last    = rsp_last_ff;

   // A data-row request always starts the shared unit
   a_data_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire && (row_ff != '0) |=> (state_ff == ST_MUL1))
      else $error("data request did not start a decode");

   // The decode channel never passes the row's last channel
   a_dch_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (dch_ff <= last_ch_ff))
      else $error("decode channel beyond channel count");

   // Among low-nibble samples, only the row's final one carries last
   a_low_last: assert property (@(posedge clock) disable iff (reset)
      emit && low_ff && (dch_ff != last_ch_ff) |=> !rsp_last_ff)
      else $error("last set on an inner low-nibble sample");

   // Row position stays inside the block
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      int'(row_ff) < ROWS_PER_BLOCK)
      else $error("row index out of range");

endmodule

// ----- rtl/mcadpcm_mac.sv -----
// ---------------------------------------------------------------------------
// mcadpcm_mac: shared predictor multiply-accumulate unit
// One 16x10 signed multiplier and one wide adder, reused for both predictor
// taps of every decode; output is the rounded, floored and clipped sample.
// ---------------------------------------------------------------------------
module mcadpcm_mac import mcadpcm_pkg::*; (
   input  logic                       clock,
   input  mac_ctl_type                ctl,
   input  logic signed [SAMPLE_W-1:0] mul_a,
   input  logic signed [COEF_W-1:0]   mul_b,
   input  logic [NIB_W-1:0]           code,
   input  logic [SHIFT_W-1:0]         shift,
   output logic signed [SAMPLE_W-1:0] sample
);

   localparam int Q_W = ACC_W - FRAC_BITS;
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(SAMPLE_MAX);
   localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(SAMPLE_MIN);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  code_ext;
   logic signed [ACC_W-1:0]  code_term;
   logic [SHIFT_W-1:0]       shamt;
   logic signed [ACC_W-1:0]  total;
   logic signed [Q_W-1:0]    quot;

   // Scale the sign-extended code: code * 2^(28 - shift)
   always_comb begin
      code_ext = {{(ACC_W-NIB_W){code[NIB_W-1]}}, code};
      if (shift > SHIFT_W'(SHIFT_BASE)) begin
         shamt = '0;
      end else begin
         shamt = SHIFT_W'(SHIFT_BASE) - shift;
      end
      code_term = code_ext <<< shamt;
   end

   // Multiply one tap, accumulate the previous one
   always_comb begin
      prod_in = prod_ff;
      acc_in  = acc_ff;
      if (ctl.load) begin
         prod_in = mul_a * mul_b;
         acc_in  = code_term + ACC_W'(ROUND_BIAS);
      end else if (ctl.accum) begin
         prod_in = mul_a * mul_b;
         acc_in  = acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Fold the last product, floor-divide by 256 and clip
   always_comb begin
      total = acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      quot  = total[ACC_W-1:FRAC_BITS];
      if (quot > Q_MAX) begin
         sample = SAMPLE_W'(SAMPLE_MAX);
      end else if (quot < Q_MIN) begin
         sample = SAMPLE_W'(SAMPLE_MIN);
      end else begin
         sample = quot[SAMPLE_W-1:0];
      end
   end

endmodule

// ----- rtl/mcadpcm_chan.sv -----
// ---------------------------------------------------------------------------
// mcadpcm_chan: per-channel decoder state file
// Sample history, predictor coefficients, shift and held low nibble for each
// channel; one write channel for header and nibble, one read channel that
// also takes the sample history update.
// ---------------------------------------------------------------------------
module mcadpcm_chan import mcadpcm_pkg::*; #(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int CH_W         = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  chan_ctl_type               ctl,
   input  logic [CH_W-1:0]            wr_ch,
   input  logic [BYTE_W-1:0]          wr_byte,
   input  logic [CH_W-1:0]            rd_ch,
   input  logic signed [SAMPLE_W-1:0] smp_data,
   output logic signed [SAMPLE_W-1:0] rd_cur,
   output logic signed [SAMPLE_W-1:0] rd_prev,
   output logic signed [COEF_W-1:0]   rd_coef1,
   output logic signed [COEF_W-1:0]   rd_coef2,
   output logic [SHIFT_W-1:0]         rd_shift,
   output logic [NIB_W-1:0]           rd_pend
);

   logic signed [SAMPLE_W-1:0] cur_ff   [MAX_CHANNELS];
   logic signed [SAMPLE_W-1:0] prev_ff  [MAX_CHANNELS];
   logic signed [COEF_W-1:0]   coef1_ff [MAX_CHANNELS];
   logic signed [COEF_W-1:0]   coef2_ff [MAX_CHANNELS];
   logic [SHIFT_W-1:0]         shift_ff [MAX_CHANNELS];
   logic [NIB_W-1:0]           pend_ff  [MAX_CHANNELS];

   logic [NIB_W-1:0]      hi_nib;
   logic [NIB_W-1:0]      lo_nib;
   logic [COEF_IDX_W-1:0] idx1;
   logic [COEF_IDX_W-1:0] idx2;

   // Split the header byte into table index and shift
   always_comb begin
      hi_nib = wr_byte[BYTE_W-1:NIB_W];
      lo_nib = wr_byte[NIB_W-1:0];
      idx1   = COEF_IDX_W'(hi_nib);
      idx2   = COEF_IDX_W'(hi_nib) + COEF_IDX_W'(COEF2_OFS);
   end

   // Update history and header fields, clear on reset or reconfiguration
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            cur_ff[i]   <= '0;
            prev_ff[i]  <= '0;
            coef1_ff[i] <= '0;
            coef2_ff[i] <= '0;
            shift_ff[i] <= '0;
         end
      end else begin
         if (ctl.hdr_we) begin
            coef1_ff[wr_ch] <= coef_lookup(idx1);
            coef2_ff[wr_ch] <= coef_lookup(idx2);
            shift_ff[wr_ch] <= SHIFT_W'(lo_nib) + SHIFT_W'(SHIFT_BIAS);
         end
         if (ctl.smp_we) begin
            prev_ff[rd_ch] <= cur_ff[rd_ch];
            cur_ff[rd_ch]  <= smp_data;
         end
      end
   end

   // Hold the low nibble until the row ends
   always_ff @(posedge clock) begin
      if (ctl.pend_we) begin
         pend_ff[wr_ch] <= wr_byte[NIB_W-1:0];
      end
   end

   assign rd_cur   = cur_ff[rd_ch];
   assign rd_prev  = prev_ff[rd_ch];
   assign rd_coef1 = coef1_ff[rd_ch];
   assign rd_coef2 = coef2_ff[rd_ch];
   assign rd_shift = shift_ff[rd_ch];
   assign rd_pend  = pend_ff[rd_ch];

endmodule
